// File: sv/sha1bsh_pkg.sv
// ----------------------------------------------------------------------------
// sha1bsh_pkg
// Shared types and constants of the byte stream SHA-1 hasher.
// ----------------------------------------------------------------------------
package sha1bsh_pkg;

    localparam int ROUND_COUNT = 80;
    localparam int PHASE_LEN   = 20;
    localparam int RND_W       = $clog2(ROUND_COUNT);

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARKER = 8'h80;

    localparam logic [4:0][31:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [31:0] K_PH0 = 32'h5A827999;
    localparam logic [31:0] K_PH1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_PH2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_PH3 = 32'hCA62C1D6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             absorb;
        logic [7:0]       byte_val;
        logic             start;
        logic             step;
        logic [RND_W-1:0] rnd;
    } core_ctl_t;

endpackage

// File: sv/sha1_byte_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_unit
// SHA-1 hasher taking one message byte per input word.
// ----------------------------------------------------------------------------
// Input: s_tdata carries a message byte, s_tuser selects data (0) or finish
// (1). Each data word is absorbed into the block; the word completing a 64-byte
// block starts the compression, which holds s_tready low through the 80
// rounds on the single round unit and the chaining update.
// A finish word pads the message one byte per cycle while no compression
// runs (0x80, zeros, 64-bit length), running one or two compressions as
// blocks fill, then presents the five digest words on m_tdata, word 0
// first, m_tlast on word 4.
// The round unit bounds the input rate: no message byte is taken while a
// block is being compressed.
// While digest words are shown s_tready is low; a stalled m_tready simply
// holds the current word. After word 4 is taken the hasher returns to its
// initial chaining values with a zero byte count, ready for a new message.
// Reset (aresetn low, synchronous) does the same and drops m_tvalid.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_tlast
);
    import sha1bsh_pkg::*;

    localparam logic [5:0]       LAST_POS = 6'd63;
    localparam logic [5:0]       LEN_POS  = 6'd56;
    localparam logic [2:0]       LAST_IDX = 3'd4;
    localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUND_COUNT - 1);

    state_t           state_reg, state_next;
    state_t           ret_reg, ret_next;
    logic [60:0]      count_reg, count_next;
    logic [63:0]      len_reg, len_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    logic [2:0]       idx_reg, idx_next;
    logic [4:0][31:0] chain_reg, chain_next;
    logic [4:0][31:0] work;
    logic [31:0]      w_cur;
    logic [5:0]       pos;
    core_ctl_t        ctl;

    assign pos = count_reg[5:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            count_reg <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            chain_reg <= H_INIT;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            count_reg <= count_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg <= len_next;
    end

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        len_next     = len_reg;
        rnd_next     = rnd_reg;
        idx_next     = idx_reg;
        chain_next   = chain_reg;
        ctl.absorb   = 1'b0;
        ctl.byte_val = '0;
        ctl.start    = 1'b0;
        ctl.step     = 1'b0;
        ctl.rnd      = rnd_reg;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == KIND_FINISH) begin
                        len_next   = {count_reg, 3'b000};
                        state_next = ST_PAD_MARK;
                    end else begin
                        ctl.absorb   = 1'b1;
                        ctl.byte_val = s_tdata;
                        ret_next     = ST_IDLE;
                    end
                end
            end
            ST_PAD_MARK: begin
                ctl.absorb   = 1'b1;
                ctl.byte_val = PAD_MARKER;
                ret_next     = ST_PAD_ZERO;
                state_next   = ST_PAD_ZERO;
            end
            ST_PAD_ZERO: begin
                if (pos == LEN_POS) begin
                    state_next = ST_PAD_LEN;
                end else begin
                    ctl.absorb = 1'b1;
                    ret_next   = ST_PAD_ZERO;
                end
            end
            ST_PAD_LEN: begin
                ctl.absorb   = 1'b1;
                ctl.byte_val = len_reg[63:56];
                len_next     = {len_reg[55:0], 8'h00};
                ret_next     = ST_OUT;
            end
            ST_ROUND: begin
                ctl.step = 1'b1;
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == LAST_RND) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                for (int i = 0; i < 5; i++) begin
                    chain_next[i] = chain_reg[i] + work[i];
                end
                state_next = ret_reg;
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (idx_reg == LAST_IDX) begin
                        idx_next   = '0;
                        chain_next = H_INIT;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (ctl.absorb && pos == LAST_POS) begin
            ctl.start  = 1'b1;
            rnd_next   = '0;
            state_next = ST_ROUND;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ctl.absorb) begin
            count_next = count_reg + 61'd1;
        end
        if (state_reg == ST_OUT && m_tready && idx_reg == LAST_IDX) begin
            count_next = '0;
        end
    end

    sha1bsh_sched u_sched (
        .aclk  (aclk),
        .ctl   (ctl),
        .w_out (w_cur)
    );

    sha1bsh_round u_round (
        .aclk  (aclk),
        .ctl   (ctl),
        .chain (chain_reg),
        .w_in  (w_cur),
        .work  (work)
    );

    assign m_tdata = {5'b00000, idx_reg, chain_reg[idx_reg]};
    assign m_tlast = (idx_reg == LAST_IDX);

endmodule

// File: sv/sha1bsh_sched.sv
// ----------------------------------------------------------------------------
// sha1bsh_sched
// Block buffer and message schedule: bytes shift in big-endian, then the
// 16-word window slides one word per round, producing W[r] at its head.
// ----------------------------------------------------------------------------
module sha1bsh_sched (
    input  logic                   aclk,
    input  sha1bsh_pkg::core_ctl_t ctl,
    output logic [31:0]            w_out
);
    import sha1bsh_pkg::*;

    logic [15:0][31:0] win_reg;
    logic [15:0][31:0] win_next;
    logic [31:0]       mix;

    // win_reg[15] holds W[r], win_reg[13] W[r+2], win_reg[7] W[r+8], win_reg[2] W[r+13]
    always_comb begin
        mix      = win_reg[15] ^ win_reg[13] ^ win_reg[7] ^ win_reg[2];
        win_next = win_reg;
        if (ctl.absorb) begin
            win_next = {win_reg[15][23:0], win_reg[14:0], ctl.byte_val};
        end else if (ctl.step) begin
            win_next = {win_reg[14:0], mix[30:0], mix[31]};
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    assign w_out = win_reg[15];

endmodule

// File: sv/sha1bsh_round.sv
// ----------------------------------------------------------------------------
// sha1bsh_round
// Shared SHA-1 round unit: working variables a..e, one round per step.
// ----------------------------------------------------------------------------
module sha1bsh_round (
    input  logic                   aclk,
    input  sha1bsh_pkg::core_ctl_t ctl,
    input  logic [4:0][31:0]       chain,
    input  logic [31:0]            w_in,
    output logic [4:0][31:0]       work
);
    import sha1bsh_pkg::*;

    logic [4:0][31:0] work_reg;
    logic [4:0][31:0] work_next;
    logic [31:0]      a, b, c, d, e;
    logic [31:0]      f_val;
    logic [31:0]      k_val;
    logic [31:0]      t_val;

    always_comb begin
        a = work_reg[0];
        b = work_reg[1];
        c = work_reg[2];
        d = work_reg[3];
        e = work_reg[4];
        priority if (ctl.rnd < RND_W'(PHASE_LEN)) begin
            f_val = (b & c) | (~b & d);
            k_val = K_PH0;
        end else if (ctl.rnd < RND_W'(2 * PHASE_LEN)) begin
            f_val = b ^ c ^ d;
            k_val = K_PH1;
        end else if (ctl.rnd < RND_W'(3 * PHASE_LEN)) begin
            f_val = (b & c) | (b & d) | (c & d);
            k_val = K_PH2;
        end else begin
            f_val = b ^ c ^ d;
            k_val = K_PH3;
        end
        t_val = {a[26:0], a[31:27]} + f_val + e + k_val + w_in;

        work_next = work_reg;
        if (ctl.start) begin
            work_next = chain;
        end else if (ctl.step) begin
            work_next[0] = t_val;
            work_next[1] = a;
            work_next[2] = {b[1:0], b[31:2]};
            work_next[3] = c;
            work_next[4] = d;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
    end

    assign work = work_reg;

endmodule
